// ----- rtl/core/bpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

    // field widths
    localparam int FUNC_W = 2;
    localparam int RANK_W = 5;
    localparam int PAGE_W = 10;
    localparam int STAT_W = 2;
    localparam int ANS_W  = 11;
    localparam int CFG_W  = 11;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE      = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QRY_RANK  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QRY_COUNT = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [RANK_W-1:0] rank;
        logic [PAGE_W-1:0] page_index;
    } bpa_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PAGE_W-1:0] granted_page;
        logic [ANS_W-1:0]  answer;
    } bpa_rsp_t;

    // per-page metadata word
    typedef struct packed {
        logic              start;
        logic              used;
        logic [RANK_W-1:0] rank;
    } bpa_entry_t;

    // control from the configuration side to the sequencer
    typedef struct packed {
        logic              restart;
        logic [RANK_W-1:0] pool_rank;
    } bpa_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/bpa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/bpa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bpa_ctrl
    import bpa_pkg::*;
#(
    parameter int POOL_PAGES = 1024,
    parameter int MAX_RANK   = 11
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bpa_cfg_t                      cfg,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire bpa_req_t                      s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output bpa_rsp_t                           m_data,
    output logic                               ram_wr_en,
    output logic [$clog2(POOL_PAGES)-1:0]      ram_wr_addr,
    output bpa_entry_t                         ram_wr_data,
    output logic [$clog2(POOL_PAGES)-1:0]      ram_rd_addr,
    input  wire bpa_entry_t                    ram_rd_data
);

    localparam int AW = $clog2(POOL_PAGES);
    localparam int XW = ((AW + 1 > MAX_RANK) ? AW + 1 : MAX_RANK) + 1;
    localparam int CW = $clog2(POOL_PAGES + 1);
    localparam int CI = $clog2(MAX_RANK + 1);
    localparam logic [XW-1:0]     NPAGES = XW'(POOL_PAGES);
    localparam logic [RANK_W-1:0] RMAX   = RANK_W'(MAX_RANK);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ALLOC_RANK, S_ALLOC_SCAN, S_ALLOC_TAKE, S_ALLOC_SPLIT,
        S_FREE_RD, S_FREE_CHK, S_MERGE_TEST, S_MERGE_RD, S_MERGE_CHK,
        S_MERGE_LO, S_MERGE_CNT, S_QRY_RD, S_QRY_CHK, S_OUT
    } state_t;

    state_t            state_reg;
    bpa_req_t          req_reg;
    bpa_rsp_t          rsp_reg;
    logic              m_valid_reg;
    logic [XW-1:0]     clr_reg;
    logic [XW-1:0]     cur_reg;
    logic [XW-1:0]     bud_reg;
    logic [XW-1:0]     scan_reg;
    logic [XW-1:0]     prev_reg;
    logic              pend_reg;
    logic [RANK_W-1:0] r_reg;
    logic [RANK_W-1:0] found_reg;
    logic [RANK_W-1:0] jr_reg;
    logic [CW-1:0]     cnt_reg [MAX_RANK+1];

    logic [XW-1:0]     split_addr;
    logic [XW-1:0]     merge_bud;
    logic              scan_hit;
    logic              merge_hit;
    logic              req_rank_ok;

    function automatic logic [XW-1:0] span_of(input logic [RANK_W-1:0] r);
        span_of = XW'(1) << (r - RANK_W'(1));
    endfunction

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

    assign split_addr  = cur_reg + span_of(jr_reg);
    assign merge_bud   = cur_reg ^ span_of(r_reg);
    assign req_rank_ok = (s_data.rank != '0) && (s_data.rank <= RMAX);
    assign scan_hit    = pend_reg && ram_rd_data.start && !ram_rd_data.used &&
                         (ram_rd_data.rank == found_reg);
    assign merge_hit   = ram_rd_data.start && !ram_rd_data.used &&
                         (ram_rd_data.rank == r_reg);

    // metadata ram port control
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = cur_reg[AW-1:0];
        ram_wr_data = '0;
        ram_rd_addr = cur_reg[AW-1:0];
        case (state_reg)
            S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg[AW-1:0];
                if (clr_reg == '0 && cfg.pool_rank != '0) begin
                    ram_wr_data = '{start: 1'b1, used: 1'b0, rank: cfg.pool_rank};
                end
            end
            S_ALLOC_SCAN: begin
                ram_rd_addr = scan_reg[AW-1:0];
            end
            S_ALLOC_TAKE: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = '{start: 1'b1, used: 1'b1, rank: req_reg.rank};
            end
            S_ALLOC_SPLIT: begin
                ram_wr_en   = (split_addr < NPAGES);
                ram_wr_addr = split_addr[AW-1:0];
                ram_wr_data = '{start: 1'b1, used: 1'b0, rank: jr_reg};
            end
            S_FREE_CHK: begin
                ram_wr_en   = ram_rd_data.start && ram_rd_data.used;
                ram_wr_data = '{start: 1'b1, used: 1'b0, rank: ram_rd_data.rank};
            end
            S_MERGE_RD: begin
                ram_rd_addr = bud_reg[AW-1:0];
            end
            S_MERGE_CHK: begin
                // the upper half of the pair stops being a block start
                ram_wr_en   = merge_hit;
                ram_wr_addr = (cur_reg < bud_reg) ? bud_reg[AW-1:0] : cur_reg[AW-1:0];
            end
            S_MERGE_LO: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = '{start: 1'b1, used: 1'b0, rank: r_reg + RANK_W'(1)};
            end
            default: begin
            end
        endcase
    end

    // sequencer, free counts and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else if (cfg.restart) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    for (int i = 0; i <= MAX_RANK; i++) begin
                        cnt_reg[i] <= (cfg.pool_rank == RANK_W'(i) && i != 0) ?
                                      CW'(1) : '0;
                    end
                    clr_reg <= clr_reg + XW'(1);
                    if (clr_reg == NPAGES - XW'(1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg <= s_data;
                        r_reg   <= s_data.rank;
                        cur_reg <= XW'(s_data.page_index);
                        case (s_data.func)
                            FUNC_ALLOC: begin
                                if (req_rank_ok) begin
                                    rsp_reg   <= '0;
                                    state_reg <= S_ALLOC_RANK;
                                end else begin
                                    rsp_reg     <= '{status: ST_BAD, granted_page: '0,
                                                     answer: '0};
                                    m_valid_reg <= 1'b1;
                                    state_reg   <= S_OUT;
                                end
                            end
                            FUNC_FREE, FUNC_QRY_RANK: begin
                                if (XW'(s_data.page_index) < NPAGES) begin
                                    rsp_reg   <= '0;
                                    state_reg <= (s_data.func == FUNC_FREE) ?
                                                 S_FREE_RD : S_QRY_RD;
                                end else begin
                                    rsp_reg     <= '{status: ST_BAD, granted_page: '0,
                                                     answer: '0};
                                    m_valid_reg <= 1'b1;
                                    state_reg   <= S_OUT;
                                end
                            end
                            default: begin
                                if (req_rank_ok) begin
                                    rsp_reg <= '{status: ST_OK, granted_page: '0,
                                                 answer: ANS_W'(cnt_reg[s_data.rank[CI-1:0]])};
                                end else begin
                                    rsp_reg <= '{status: ST_BAD, granted_page: '0,
                                                 answer: '0};
                                end
                                m_valid_reg <= 1'b1;
                                state_reg   <= S_OUT;
                            end
                        endcase
                    end
                end
                // smallest rank at or above the request with a free block
                S_ALLOC_RANK: begin
                    if (cnt_reg[r_reg[CI-1:0]] != '0) begin
                        found_reg <= r_reg;
                        scan_reg  <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= S_ALLOC_SCAN;
                    end else if (r_reg == RMAX) begin
                        rsp_reg.status <= ST_NO_SPACE;
                        m_valid_reg    <= 1'b1;
                        state_reg      <= S_OUT;
                    end else begin
                        r_reg <= r_reg + RANK_W'(1);
                    end
                end
                // walk aligned starts of that rank, one read in flight
                S_ALLOC_SCAN: begin
                    if (scan_hit) begin
                        cur_reg   <= prev_reg;
                        state_reg <= S_ALLOC_TAKE;
                    end else if (scan_reg < NPAGES) begin
                        prev_reg <= scan_reg;
                        scan_reg <= scan_reg + span_of(found_reg);
                        pend_reg <= 1'b1;
                    end else begin
                        rsp_reg.status <= ST_NO_SPACE;
                        m_valid_reg    <= 1'b1;
                        state_reg      <= S_OUT;
                    end
                end
                S_ALLOC_TAKE: begin
                    cnt_reg[found_reg[CI-1:0]] <= cnt_reg[found_reg[CI-1:0]] - CW'(1);
                    jr_reg <= req_reg.rank;
                    if (req_reg.rank == found_reg) begin
                        rsp_reg.status       <= ST_OK;
                        rsp_reg.granted_page <= PAGE_W'(cur_reg);
                        m_valid_reg          <= 1'b1;
                        state_reg            <= S_OUT;
                    end else begin
                        state_reg <= S_ALLOC_SPLIT;
                    end
                end
                // free buddies of ascending rank above the granted block
                S_ALLOC_SPLIT: begin
                    if (split_addr < NPAGES) begin
                        cnt_reg[jr_reg[CI-1:0]] <= cnt_reg[jr_reg[CI-1:0]] + CW'(1);
                    end
                    jr_reg <= jr_reg + RANK_W'(1);
                    if (jr_reg + RANK_W'(1) == found_reg) begin
                        rsp_reg.status       <= ST_OK;
                        rsp_reg.granted_page <= PAGE_W'(cur_reg);
                        m_valid_reg          <= 1'b1;
                        state_reg            <= S_OUT;
                    end
                end
                S_FREE_RD: begin
                    state_reg <= S_FREE_CHK;
                end
                S_FREE_CHK: begin
                    if (!(ram_rd_data.start && ram_rd_data.used)) begin
                        rsp_reg.status <= ST_BAD;
                        m_valid_reg    <= 1'b1;
                        state_reg      <= S_OUT;
                    end else if (ram_rd_data.rank == '0 || ram_rd_data.rank > RMAX) begin
                        rsp_reg.status <= ST_OK;
                        m_valid_reg    <= 1'b1;
                        state_reg      <= S_OUT;
                    end else begin
                        r_reg <= ram_rd_data.rank;
                        cnt_reg[ram_rd_data.rank[CI-1:0]] <=
                            cnt_reg[ram_rd_data.rank[CI-1:0]] + CW'(1);
                        state_reg <= S_MERGE_TEST;
                    end
                end
                // merge chain, one level per pass
                S_MERGE_TEST: begin
                    if (r_reg >= RMAX || merge_bud >= NPAGES) begin
                        rsp_reg.status <= ST_OK;
                        m_valid_reg    <= 1'b1;
                        state_reg      <= S_OUT;
                    end else begin
                        bud_reg   <= merge_bud;
                        state_reg <= S_MERGE_RD;
                    end
                end
                S_MERGE_RD: begin
                    state_reg <= S_MERGE_CHK;
                end
                S_MERGE_CHK: begin
                    if (merge_hit) begin
                        cur_reg   <= (cur_reg < bud_reg) ? cur_reg : bud_reg;
                        state_reg <= S_MERGE_LO;
                    end else begin
                        rsp_reg.status <= ST_OK;
                        m_valid_reg    <= 1'b1;
                        state_reg      <= S_OUT;
                    end
                end
                S_MERGE_LO: begin
                    cnt_reg[r_reg[CI-1:0]] <= cnt_reg[r_reg[CI-1:0]] - CW'(2);
                    state_reg <= S_MERGE_CNT;
                end
                S_MERGE_CNT: begin
                    cnt_reg[CI'(r_reg + RANK_W'(1))] <=
                        cnt_reg[CI'(r_reg + RANK_W'(1))] + CW'(1);
                    r_reg     <= r_reg + RANK_W'(1);
                    state_reg <= S_MERGE_TEST;
                end
                S_QRY_RD: begin
                    state_reg <= S_QRY_CHK;
                end
                S_QRY_CHK: begin
                    if (ram_rd_data.start) begin
                        rsp_reg.status <= ST_OK;
                        rsp_reg.answer <= ANS_W'(ram_rd_data.rank);
                    end else begin
                        rsp_reg.status <= ST_BAD;
                    end
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // a result is only ever shown from the output state
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (state_reg == S_OUT))
        else $error("result valid outside output state");

    // splitting never reaches the rank that was found
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ALLOC_SPLIT) |-> (jr_reg < found_reg))
        else $error("split rank overran found rank");

    // an accepted beat closes the input until its result is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !cfg.restart) |=> !s_ready)
        else $error("input ready after accept");

    // merging only continues below the top rank
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MERGE_RD) |-> (r_reg < RMAX))
        else $error("merge beyond top rank");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/buddy_page_allocator_top.sv -----
//  channel  | handshake            | beat
//  ---------+----------------------+-------------------------------
//  request  | s_valid / s_ready    | s_data  (func, rank, page_index)
//  result   | m_valid / m_ready    | m_data  (status, granted_page, answer)
//  config   | cfg_wr_en (no wait)  | cfg_wr_data (pool_pages)
//
//  one request at a time on a one-read one-write metadata ram; a query
//  reads at most one entry, a free reads the freed entry and then one buddy
//  per merge level, an allocate makes up to MAX_RANK rank probes plus one
//  read per aligned block start of the found rank, then at most one write
//  per split level. after reset and after each pool_pages write a clearing
//  pass over all POOL_PAGES entries runs before the first request is taken.
//  a stalled result holds the block; s_ready stays low until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module buddy_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int POOL_PAGES = 1024,
    parameter int MAX_RANK   = 11
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire bpa_req_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output bpa_rsp_t              m_data,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data
);

    localparam int AW = $clog2(POOL_PAGES);
    localparam int PW = $clog2(POOL_PAGES + 1);
    localparam int XW = ((PW > MAX_RANK) ? PW : MAX_RANK) + 2;
    localparam logic [PW-1:0] POOL_RESET = (POOL_PAGES < 1024) ?
                                           PW'(POOL_PAGES) : PW'(1024);

    logic [PW-1:0]     pool_reg;
    logic [PW-1:0]     pool_next;
    logic [RANK_W-1:0] pool_rank;
    bpa_cfg_t          cfg;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    bpa_entry_t        ram_wr_data;
    logic [AW-1:0]     ram_rd_addr;
    bpa_entry_t        ram_rd_data;

    // page count register, clamped to the storage
    always_comb begin
        if (XW'(cfg_wr_data) > XW'(POOL_PAGES)) begin
            pool_next = PW'(POOL_PAGES);
        end else begin
            pool_next = PW'(cfg_wr_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg <= POOL_RESET;
        end else if (cfg_wr_en) begin
            pool_reg <= pool_next;
        end
    end

    // rank of the largest power of two not above the page count
    always_comb begin
        pool_rank = '0;
        for (int r = 1; r <= MAX_RANK; r++) begin
            if ((XW'(1) << (r - 1)) <= XW'(pool_reg)) begin
                pool_rank = RANK_W'(r);
            end
        end
    end

    assign cfg.restart   = cfg_wr_en;
    assign cfg.pool_rank = pool_rank;

    bpa_ram #(
        .WIDTH ($bits(bpa_entry_t)),
        .DEPTH (POOL_PAGES)
    ) u_meta_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    bpa_ctrl #(
        .POOL_PAGES (POOL_PAGES),
        .MAX_RANK   (MAX_RANK)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

// ----- tb/buddy_page_allocator_checker.sv -----
`timescale 1ns / 1ps

module buddy_page_allocator_checker
    import bpa_pkg::*;
#(
    parameter int POOL_PAGES = 1024,
    parameter int MAX_RANK   = 11
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_ready,
    input  wire bpa_req_t         s_data,
    input  wire logic             m_valid,
    input  wire logic             m_ready,
    input  wire bpa_rsp_t         m_data,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    output int                    fail_count,
    output int                    pending,
    output int                    checked
);

    // allocator shadow state
    bit                start_f [POOL_PAGES];
    bit                used_f  [POOL_PAGES];
    logic [RANK_W-1:0] rank_of [POOL_PAGES];
    int unsigned       free_cnt [MAX_RANK+1];
    bpa_rsp_t          rsp_queue [$];

    // rebuild the pool as one free block
    function void rebuild_pool(input int unsigned pages);
        int unsigned p;
        for (int i = 0; i < POOL_PAGES; i++) begin
            start_f[i] = 0;
            used_f[i]  = 0;
            rank_of[i] = '0;
        end
        for (int r = 0; r <= MAX_RANK; r++) free_cnt[r] = 0;
        p = (pages > POOL_PAGES) ? POOL_PAGES : pages;
        for (int r = MAX_RANK; r >= 1; r--) begin
            if ((1 << (r - 1)) <= p) begin
                start_f[0]  = 1;
                rank_of[0]  = r;
                free_cnt[r] = 1;
                break;
            end
        end
    endfunction

    // work out the result of one request and update the shadow state
    function bpa_rsp_t predict_result(input bpa_req_t req);
        bpa_rsp_t    rsp;
        int          found;
        int          s;
        int          b;
        int          r;
        int          lo;
        int          hi;
        rsp = '0;
        rsp.status = ST_BAD;
        case (req.func)
            FUNC_ALLOC: begin
                if (req.rank >= 1 && req.rank <= MAX_RANK) begin
                    found = 0;
                    for (r = req.rank; r <= MAX_RANK; r++)
                        if (free_cnt[r] != 0) begin
                            found = r;
                            break;
                        end
                    s = -1;
                    if (found != 0)
                        for (int p = 0; p < POOL_PAGES; p++)
                            if (start_f[p] && !used_f[p] && rank_of[p] == found) begin
                                s = p;
                                break;
                            end
                    if (s < 0) begin
                        rsp.status = ST_NO_SPACE;
                    end else begin
                        free_cnt[found]--;
                        rank_of[s] = req.rank;
                        used_f[s]  = 1;
                        for (int j = req.rank; j < found; j++) begin
                            b = s + (1 << (j - 1));
                            if (b < POOL_PAGES) begin
                                start_f[b] = 1;
                                rank_of[b] = j;
                                used_f[b]  = 0;
                                free_cnt[j]++;
                            end
                        end
                        rsp.status       = ST_OK;
                        rsp.granted_page = s;
                    end
                end
            end
            FUNC_FREE: begin
                s = req.page_index;
                if (s < POOL_PAGES && start_f[s] && used_f[s]) begin
                    used_f[s] = 0;
                    r = rank_of[s];
                    rsp.status = ST_OK;
                    if (r >= 1 && r <= MAX_RANK) begin
                        free_cnt[r]++;
                        // merge upwards while the buddy is a free block of equal rank
                        while (r < MAX_RANK) begin
                            b = s ^ (1 << (r - 1));
                            if (b >= POOL_PAGES || !start_f[b] || used_f[b] ||
                                rank_of[b] != r)
                                break;
                            lo = (s < b) ? s : b;
                            hi = (s < b) ? b : s;
                            start_f[hi] = 0;
                            rank_of[hi] = '0;
                            rank_of[lo] = r + 1;
                            free_cnt[r] -= 2;
                            free_cnt[r+1]++;
                            s = lo;
                            r++;
                        end
                    end
                end
            end
            FUNC_QRY_RANK: begin
                if (req.page_index < POOL_PAGES && start_f[req.page_index]) begin
                    rsp.status = ST_OK;
                    rsp.answer = rank_of[req.page_index];
                end
            end
            default: begin
                if (req.rank >= 1 && req.rank <= MAX_RANK) begin
                    rsp.status = ST_OK;
                    rsp.answer = free_cnt[req.rank];
                end
            end
        endcase
        return rsp;
    endfunction

    assign pending = rsp_queue.size();

    // watch the channels, predict on request beats, compare on result beats
    always @(posedge aclk) begin
        bpa_rsp_t want;
        if (!aresetn) begin
            rebuild_pool(1024);
            rsp_queue.delete();
            fail_count <= 0;
            checked    <= 0;
        end else begin
            if (cfg_wr_en) rebuild_pool(cfg_wr_data);
            if (s_valid && s_ready) rsp_queue.push_back(predict_result(s_data));
            if (m_valid && m_ready) begin
                checked <= checked + 1;
                if (rsp_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result beat with nothing expected: %p", $realtime,
                                 m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = rsp_queue.pop_front();
                    if (m_data.status !== want.status ||
                        m_data.granted_page !== want.granted_page ||
                        m_data.answer !== want.answer) begin
                        if (fail_count < 10)
                            $display("%0t: mismatch exp st=%0d pg=%0d ans=%0d got st=%0d pg=%0d ans=%0d",
                                     $realtime, want.status, want.granted_page, want.answer,
                                     m_data.status, m_data.granted_page, m_data.answer);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/buddy_page_allocator_top_tb.sv -----
`timescale 1ns / 1ps

module buddy_page_allocator_top_tb;
    import bpa_pkg::*;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    bpa_req_t         s_data;
    logic             m_valid;
    logic             m_ready;
    bpa_rsp_t         m_data;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    int               fail_count;
    int               pending;
    int               checked;
    bit               long_hold;
    int               burst_left;
    logic [9:0]       granted_pages [$];
    int               n_sent;

    buddy_page_allocator_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    buddy_page_allocator_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode;
        int cnt;
        m_ready = 0;
        cnt = 0;
        mode = 0;
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_ready <= 0;
                for (int i = 0; i < 400; i++) @(posedge aclk);
                long_hold = 0;
            end else begin
                if (cnt == 0) begin
                    mode = $urandom_range(0, 2);
                    cnt = $urandom_range(10, 80);
                end
                cnt--;
                case (mode)
                    0: m_ready <= 1;
                    1: m_ready <= $urandom_range(0, 1);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // granted pages feed later frees
    always @(posedge aclk)
        if (aresetn && m_valid && m_ready && m_data.status == ST_OK && m_data.answer == 0
            && granted_pages.size() < 256)
            granted_pages.push_back(m_data.granted_page);

    // offer one request beat and wait for it to be taken
    task automatic send_req(input logic [1:0] f, input logic [4:0] r, input logic [9:0] p);
        s_valid <= 1;
        s_data.func <= f;
        s_data.rank <= r;
        s_data.page_index <= p;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    // random bursts with gaps between them
    task automatic send_bursty(input logic [1:0] f, input logic [4:0] r, input logic [9:0] p);
        send_req(f, r, p);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            s_valid <= 0;
            repeat ($urandom_range(0, 1) ? $urandom_range(1, 30) : 1) @(posedge aclk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_pool(input logic [CFG_W-1:0] v);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
        granted_pages.delete();
    endtask

    // one random request, mostly well-formed allocate and free traffic
    task automatic random_req();
        int sel;
        int k;
        logic [4:0] r;
        logic [9:0] p;
        sel = $urandom_range(0, 99);
        r = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 4));
        p = 10'($urandom);
        if (sel < 45) begin
            send_bursty(FUNC_ALLOC, r, p);
        end else if (sel < 80 && granted_pages.size() > 0) begin
            k = $urandom_range(0, granted_pages.size() - 1);
            p = granted_pages[k];
            granted_pages.delete(k);
            send_bursty(FUNC_FREE, r, p);
        end else if (sel < 85) begin
            send_bursty(FUNC_FREE, r, p);
        end else if (sel < 95) begin
            if (granted_pages.size() > 0 && $urandom_range(0, 1))
                p = granted_pages[$urandom_range(0, granted_pages.size() - 1)];
            send_bursty(FUNC_QRY_RANK, r, p);
        end else begin
            send_bursty(FUNC_QRY_COUNT, 5'($urandom), p);
        end
    endtask

    initial begin
        int pools [10] = '{64, 2047, 1, 2, 3, 100, 16, 0, 1024, 700};
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        cfg_wr_en = 0;
        cfg_wr_data = '0;
        long_hold = 0;
        burst_left = 0;
        n_sent = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: full pool after reset
        send_req(FUNC_QRY_COUNT, 11, 0);
        send_req(FUNC_ALLOC, 0, 0);
        send_req(FUNC_ALLOC, 12, 0);
        send_req(FUNC_ALLOC, 31, 10'h3ff);
        send_req(FUNC_ALLOC, 1, 0);
        send_req(FUNC_ALLOC, 11, 0);
        send_req(FUNC_QRY_RANK, 0, 0);
        send_req(FUNC_QRY_RANK, 0, 1);
        send_req(FUNC_QRY_RANK, 0, 3);
        send_req(FUNC_FREE, 0, 5);
        send_req(FUNC_FREE, 0, 1);
        send_req(FUNC_FREE, 0, 0);
        send_req(FUNC_QRY_COUNT, 11, 0);
        send_req(FUNC_ALLOC, 11, 0);
        send_req(FUNC_FREE, 0, 0);
        send_req(FUNC_ALLOC, 10, 0);
        send_req(FUNC_ALLOC, 10, 0);
        send_req(FUNC_ALLOC, 10, 0);
        send_req(FUNC_FREE, 0, 512);
        send_req(FUNC_FREE, 0, 0);
        send_req(FUNC_QRY_RANK, 0, 10'h3ff);
        send_req(FUNC_QRY_COUNT, 0, 0);
        wait_idle();
        // empty pool
        write_pool(0);
        send_req(FUNC_ALLOC, 1, 0);
        send_req(FUNC_QRY_COUNT, 1, 0);
        send_req(FUNC_QRY_RANK, 0, 0);
        wait_idle();

        // random phases over several pool sizes
        foreach (pools[i]) begin
            write_pool(pools[i]);
            for (int n = 0; n < 155; n++) begin
                if (i == 1 && n == 50) long_hold = 1;
                random_req();
            end
            wait_idle();
        end

        $display("%0d requests sent, directed checks plus %0d random pool phases",
                 n_sent, $size(pools));
        $display("%0d results checked", checked);
        if (fail_count == 0)
            $display("buddy_page_allocator_top regression: pass");
        else
            $display("buddy_page_allocator_top regression: fail");
        $finish;
    end

    // run limit
    initial begin
        #200ms;
        $display("timeout after %0t", $realtime);
        $display("buddy_page_allocator_top regression: fail");
        $finish;
    end

endmodule
